/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SWA_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication checked in the same cycle.
`define SWA_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/swa_pkg.sv */
`timescale 1ns / 1ps

package swa_pkg;

    // Window shapes
    typedef enum logic [1:0] {
        WK_HAMMING  = 2'd0,
        WK_HANN     = 2'd1,
        WK_BLACKMAN = 2'd2,
        WK_FEJER    = 2'd3
    } window_kind_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_WINDOW_KIND  = 2'd0;
    localparam logic [1:0] CFG_FRAME_LENGTH = 2'd1;
    localparam logic [1:0] CFG_PHASE_STEP   = 2'd2;

    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 24;
    localparam int FRAME_LEN_W   = 13;
    localparam int PHASE_W       = 24;
    localparam int COEF_W        = 16;
    localparam int QUEUE_DEPTH   = 4;

    // Register reset values
    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET  = 13'd512;
    localparam logic [PHASE_W-1:0]     PHASE_STEP_RESET = 24'd32768;

    // Q1.15 unity and Q2.30 window offsets
    localparam logic [COEF_W-1:0] COEF_ONE = 16'd32768;
    localparam logic signed [32:0] HAMM_OFFSET_Q30  = 33'sd579829760;  // 0.54
    localparam logic signed [32:0] HANN_OFFSET_Q30  = 33'sd536870912;  // 0.5
    localparam logic signed [32:0] BLACK_OFFSET_Q30 = 33'sd450985984;  // 0.42
    localparam logic signed [32:0] HAMM_COS_GAIN    = 33'sd15073;      // 0.46
    localparam logic signed [32:0] BLACK_COS2_GAIN  = 33'sd2621;       // 0.08

    // Cosine table generation (Taylor series in Q2.30)
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] COS_DENS [7] = '{64'd182, 64'd132, 64'd90, 64'd56,
                                             64'd30, 64'd12, 64'd2};

    // Configuration bundle shared by front and back
    typedef struct packed {
        window_kind_t             kind;
        logic [FRAME_LEN_W-1:0]   frame_length;
        logic [PHASE_W-1:0]       phase_step;
    } cfg_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PHASE,
        BK_ADDR,
        BK_ROM,
        BK_SUM,
        BK_COEF,
        BK_MUL,
        BK_OUT
    } back_state_t;

endpackage

/* src/swa_fifo.sv */
`timescale 1ns / 1ps

module swa_fifo
#(
    parameter int WIDTH = 29,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/swa_front.sv */
`timescale 1ns / 1ps

module swa_front
    import swa_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_FRAME   = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   q_full,
    output logic                   q_push,
    output logic [SAMPLE_BITS+$clog2(((MAX_FRAME < (1 << FRAME_LEN_W) - 1) ?
                   MAX_FRAME : (1 << FRAME_LEN_W) - 1)):0] q_data
);

    // Largest usable frame: limited by the parameter and the register width
    localparam int EFF_MAX = (MAX_FRAME < (1 << FRAME_LEN_W) - 1) ?
                             MAX_FRAME : (1 << FRAME_LEN_W) - 1;
    localparam int POS_W   = $clog2(EFF_MAX);
    localparam logic [FRAME_LEN_W-1:0] N_MAX = FRAME_LEN_W'(EFF_MAX);
    localparam logic [FRAME_LEN_W-1:0] N_MIN = FRAME_LEN_W'(2);

    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [FRAME_LEN_W-1:0] n_eff;
    logic [FRAME_LEN_W-1:0] half;
    logic [FRAME_LEN_W-1:0] pos_x;
    logic [FRAME_LEN_W-1:0] j;
    logic [FRAME_LEN_W-1:0] k;
    logic                   last;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Clamp frame length and classify the position in the frame
    always_comb
    begin
        if (cfg.frame_length < N_MIN)
        begin
            n_eff = N_MIN;
        end
        else if (cfg.frame_length > N_MAX)
        begin
            n_eff = N_MAX;
        end
        else
        begin
            n_eff = cfg.frame_length;
        end
        half  = n_eff >> 1;
        pos_x = FRAME_LEN_W'(pos_reg);
        j     = (pos_x >= n_eff) ? '0 : pos_x;
        // mirrored index; middle sample mirrors only for the triangular window
        if (j < half || (j == half && cfg.kind != WK_FEJER))
        begin
            k = j;
        end
        else
        begin
            k = n_eff - 1'b1 - j;
        end
        last     = (j == n_eff - 1'b1);
        pos_next = last ? '0 : POS_W'(j + 1'b1);
    end

    assign q_data = {sample, k[POS_W-1:0], last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (q_push)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

/* src/swa_back.sv */
`timescale 1ns / 1ps

module swa_back
    import swa_pkg::*;
#(
    parameter int SAMPLE_BITS     = 16,
    parameter int POS_W           = 12,
    parameter int COS_TABLE_DEPTH = 1024
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  logic                         q_empty,
    input  logic [SAMPLE_BITS+POS_W:0]   q_data,
    output logic                         q_pop,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [SAMPLE_BITS-1:0]       windowed_sample,
    output logic [COEF_W-1:0]            coefficient,
    output logic                         last_in_frame
);

    localparam int AW  = $clog2(COS_TABLE_DEPTH + 1);
    localparam int PW  = POS_W + PHASE_W;
    localparam int MW  = SAMPLE_BITS + 17;
    localparam int FRAC_W = PHASE_W - 2;
    localparam logic [AW-1:0] DEPTH_A = AW'(COS_TABLE_DEPTH);
    localparam logic signed [MW-1:0] ROUND_HALF = MW'(16384);
    localparam logic signed [MW-16:0] SMAX_X =
        {{(MW - 15 - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [MW-16:0] SMIN_X =
        {{(MW - 15 - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    typedef logic [COS_TABLE_DEPTH:0][COEF_W-1:0] rom_image_t;

    // Quarter-wave cosine table, Q1.15, built at elaboration
    function automatic rom_image_t build_cos_rom();
        rom_image_t  img;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] r;
        logic [63:0] p;
        for (int a = 0; a <= COS_TABLE_DEPTH; a++)
        begin
            u  = (HALF_PI_Q30 * 64'(a)) / COS_TABLE_DEPTH;
            u2 = (u * u) >> 30;
            r  = Q30_ONE;
            for (int i = 0; i < 6; i++)
            begin
                r = Q30_ONE - ((u2 * r) >> 30) / COS_DENS[i];
            end
            p = ((u2 * r) >> 30) / COS_DENS[6];
            r = (p > Q30_ONE) ? 64'd0 : Q30_ONE - p;
            r = (r + 64'd16384) >> 15;
            if (r > 64'd32768)
            begin
                r = 64'd32768;
            end
            img[a] = r[COEF_W-1:0];
        end
        return img;
    endfunction

    localparam rom_image_t COS_ROM = build_cos_rom();

    back_state_t state_reg, state_next;
    logic        out_load;

    logic [SAMPLE_BITS-1:0]   q_sample;
    logic [POS_W-1:0]         q_k;
    logic                     q_last;

    logic [SAMPLE_BITS-1:0]   sample_reg;
    logic [POS_W-1:0]         k_reg;
    logic                     last_reg;
    logic [PW-1:0]            prod_reg;
    logic [AW-1:0]            addr1_reg, addr2_reg;
    logic                     neg1_reg, neg2_reg;
    logic [COEF_W-1:0]        fej_reg;
    logic [COEF_W-1:0]        rom1_reg, rom2_reg;
    logic signed [32:0]       sum_reg;
    logic [COEF_W-1:0]        w_reg;
    logic signed [MW-1:0]     mprod_reg;

    logic                     out_valid_reg;
    logic [SAMPLE_BITS-1:0]   out_sample_reg;
    logic [COEF_W-1:0]        out_coef_reg;
    logic                     out_last_reg;

    assign {q_sample, q_k, q_last} = q_data;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  state_next = q_empty ? BK_IDLE : BK_PHASE;
            BK_PHASE: state_next = BK_ADDR;
            BK_ADDR:  state_next = BK_ROM;
            BK_ROM:   state_next = BK_SUM;
            BK_SUM:   state_next = BK_COEF;
            BK_COEF:  state_next = BK_MUL;
            BK_MUL:   state_next = BK_OUT;
            BK_OUT:   state_next = (!out_valid_reg || out_ready) ? BK_IDLE : BK_OUT;
            default:  state_next = BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            BK_IDLE: q_pop    = !q_empty;
            BK_OUT:  out_load = !out_valid_reg || out_ready;
            default:
            begin
                q_pop    = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Address generation: quadrant fold of both phases, triangular value
    logic [PHASE_W-1:0]   ph1, ph2;
    logic [FRAC_W+AW-1:0] scaled1, scaled2;
    logic [AW-1:0]        a1, a2;
    logic [PW+1:0]        fej_sum;
    logic [PW-8:0]        fej_sh;

    always_comb
    begin
        ph1     = prod_reg[PHASE_W-1:0];
        ph2     = {ph1[PHASE_W-2:0], 1'b0};
        scaled1 = (FRAC_W + AW)'(ph1[FRAC_W-1:0]) * (FRAC_W + AW)'(COS_TABLE_DEPTH);
        scaled2 = (FRAC_W + AW)'(ph2[FRAC_W-1:0]) * (FRAC_W + AW)'(COS_TABLE_DEPTH);
        a1      = scaled1[FRAC_W+AW-1:FRAC_W];
        a2      = scaled2[FRAC_W+AW-1:FRAC_W];
        fej_sum = {1'b0, prod_reg, 1'b0} + (PW + 2)'(256);
        fej_sh  = fej_sum[PW+1:9];
    end

    // Signed cosine values and window sums
    logic signed [32:0] c1_x, c2_x;
    logic signed [32:0] sum_next;
    logic [17:0]        rnd;
    logic signed [MW-1:0] mul_full;
    logic signed [MW-16:0] r_full;
    logic [SAMPLE_BITS-1:0] sat;

    always_comb
    begin
        c1_x = neg1_reg ? -$signed(33'(rom1_reg)) : $signed(33'(rom1_reg));
        c2_x = neg2_reg ? -$signed(33'(rom2_reg)) : $signed(33'(rom2_reg));
        unique case (cfg.kind)
            WK_HAMMING:  sum_next = HAMM_OFFSET_Q30 - HAMM_COS_GAIN * c1_x;
            WK_HANN:     sum_next = HANN_OFFSET_Q30 - (c1_x <<< 14);
            WK_BLACKMAN: sum_next = BLACK_OFFSET_Q30 - (c1_x <<< 14)
                                    + BLACK_COS2_GAIN * c2_x;
            default:     sum_next = '0;
        endcase
        rnd      = 18'((sum_reg + 33'sd16384) >>> 15);
        mul_full = $signed(sample_reg) * $signed({1'b0, w_reg});
        r_full   = (MW - 15)'(mprod_reg >>> 15);
        if (r_full > SMAX_X)
        begin
            sat = SMAX_X[SAMPLE_BITS-1:0];
        end
        else if (r_full < SMIN_X)
        begin
            sat = SMIN_X[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat = r_full[SAMPLE_BITS-1:0];
        end
    end

    // Datapath registers, one step per sequencer state
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_pop)
                begin
                    sample_reg <= q_sample;
                    k_reg      <= q_k;
                    last_reg   <= q_last;
                end
            end
            BK_PHASE:
            begin
                prod_reg <= PW'(k_reg) * PW'(cfg.phase_step);
            end
            BK_ADDR:
            begin
                addr1_reg <= (ph1[PHASE_W-1:PHASE_W-2] == 2'd1 ||
                              ph1[PHASE_W-1:PHASE_W-2] == 2'd3) ? DEPTH_A - a1 : a1;
                addr2_reg <= (ph2[PHASE_W-1:PHASE_W-2] == 2'd1 ||
                              ph2[PHASE_W-1:PHASE_W-2] == 2'd3) ? DEPTH_A - a2 : a2;
                neg1_reg  <= (ph1[PHASE_W-1:PHASE_W-2] == 2'd1 ||
                              ph1[PHASE_W-1:PHASE_W-2] == 2'd2);
                neg2_reg  <= (ph2[PHASE_W-1:PHASE_W-2] == 2'd1 ||
                              ph2[PHASE_W-1:PHASE_W-2] == 2'd2);
                fej_reg   <= (fej_sh > (PW - 7)'(COEF_ONE)) ? COEF_ONE
                                                            : fej_sh[COEF_W-1:0];
            end
            BK_ROM:
            begin
                rom1_reg <= COS_ROM[addr1_reg];
                rom2_reg <= COS_ROM[addr2_reg];
            end
            BK_SUM:
            begin
                sum_reg <= sum_next;
            end
            BK_COEF:
            begin
                // triangular value as is; otherwise clamp at zero, round to Q1.15, limit to unity
                if (cfg.kind == WK_FEJER)
                begin
                    w_reg <= fej_reg;
                end
                else if (sum_reg < 0)
                begin
                    w_reg <= '0;
                end
                else if (rnd > 18'(COEF_ONE))
                begin
                    w_reg <= COEF_ONE;
                end
                else
                begin
                    w_reg <= rnd[COEF_W-1:0];
                end
            end
            BK_MUL:
            begin
                mprod_reg <= mul_full + ROUND_HALF;
            end
            BK_OUT:
            begin
                if (out_load)
                begin
                    out_sample_reg <= sat;
                    out_coef_reg   <= w_reg;
                    out_last_reg   <= last_reg;
                end
            end
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign windowed_sample = out_sample_reg;
    assign coefficient     = out_coef_reg;
    assign last_in_frame   = out_last_reg;

endmodule

/* src/sample_window_apply_top.sv */
`timescale 1ns / 1ps

// Window function applied to a stream of signed Q1.15 samples in frames of
// frame_length samples (Hamming, Hann, Blackman or triangular, picked by
// window_kind). Each request steps through the back-end sequencer in order:
// queue pop, phase multiply, quadrant fold, cosine ROM read, window sum,
// coefficient rounding, sample multiply and the output register load. The
// front accepts into a 4-entry queue, so while the output is stalled up to six
// requests are held: four in the queue, one finished in the sequencer and one
// in the output register. The sequencer pops the next request only once the
// previous one is in the output register. Each result carries the rounded,
// saturated product, the Q1.15 coefficient used and the frame's last-sample flag.
// Configuration writes (index 0 window_kind, 1 frame_length, 2 phase_step,
// 2^24/N) are always accepted and should be made while the block is idle.

`include "assert_macros.svh"

module sample_window_apply_top
    import swa_pkg::*;
#(
    parameter int MAX_FRAME       = 4096,
    parameter int COS_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS     = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] windowed_sample,
    output logic [COEF_W-1:0]      coefficient,
    output logic                   last_in_frame
);

    localparam int EFF_MAX = (MAX_FRAME < (1 << FRAME_LEN_W) - 1) ?
                             MAX_FRAME : (1 << FRAME_LEN_W) - 1;
    localparam int POS_W   = $clog2(EFF_MAX);
    localparam int ITEM_W  = SAMPLE_BITS + POS_W + 1;

    cfg_t cfg_reg, cfg_next;

    logic              q_push, q_pop, q_full, q_empty;
    logic [ITEM_W-1:0] q_wdata, q_rdata;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WINDOW_KIND:  cfg_next.kind = window_kind_t'(cfg_data[1:0]);
                CFG_FRAME_LENGTH: cfg_next.frame_length = cfg_data[FRAME_LEN_W-1:0];
                CFG_PHASE_STEP:   cfg_next.phase_step = cfg_data[PHASE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kind         <= WK_HAMMING;
            cfg_reg.frame_length <= FRAME_LEN_RESET;
            cfg_reg.phase_step   <= PHASE_STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: position tracking and mirrored index
    swa_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_FRAME   (MAX_FRAME)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sample   (sample),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    // Queue between front and back
    swa_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back: coefficient and product
    swa_back #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .POS_W           (POS_W),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_empty         (q_empty),
        .q_data          (q_rdata),
        .q_pop           (q_pop),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .windowed_sample (windowed_sample),
        .coefficient     (coefficient),
        .last_in_frame   (last_in_frame)
    );

    // Checks
    `SWA_ASSERT_IMPLIES(a_push_has_room, q_push, !q_full, "queue push while full")
    `SWA_ASSERT_IMPLIES(a_pop_has_data, q_pop, !q_empty, "queue pop while empty")
    `SWA_ASSERT_IMPLIES(a_coef_bounded, out_valid, coefficient <= COEF_ONE,
                        "coefficient above unity")

endmodule
